/* rtl/core/text_console_writer_defines.svh */
// Assertion macros shared by the console writer RTL.
// Included by the top level; depends on nothing else.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TCW_ASSERT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Next-cycle implication that is also checked while reset is applied.
`define TCW_ASSERT_NEXT(LBL, CLK, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

/* rtl/core/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// Used by every module of the block but tcw_ram; depends on nothing.
`default_nettype none

package tcw_pkg;

  localparam int CELL_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int CMD_W    = 3;
  localparam int COL_IN_W = 7;
  localparam int ROW_IN_W = 5;
  localparam int POS_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;
  // Widths of the cursor move arithmetic, sized for the largest screen.
  localparam int X_W = 8;
  localparam int Y_W = 7;

  localparam logic [CMD_W-1:0] CMD_PUT_DEFAULT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUT_COLOR   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_CURSOR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ        = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 2'd2;

  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_FG     = 4'h7;
  localparam logic [COLOR_W-1:0] RESET_BG     = 4'h0;
  localparam logic [CELL_W-1:0]  RESET_CELL   = {RESET_BG, RESET_FG, BLANK_CHAR};

  // Operation decided by the front end for each request.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_NEWLINE,
    OP_SETCUR,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [CELL_W-1:0]   cell_word;
    logic [COL_IN_W-1:0] col;
    logic [ROW_IN_W-1:0] row;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/text_console_writer.sv */
// Text console writer top level: configuration registers, front end,
// request queue and back end. Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back.
//
// Usage. Requests enter on the in_ channel (in_valid, in_stall, one port per
// field) and are taken at a clock edge where in_valid is high and in_stall low.
// Every request yields exactly one result on the out_ channel, taken where
// out_valid is high and out_stall low; results come out in request order.
// Configuration (text mode, default colors) uses the cfg_ channel, always ready;
// the user must write it only while no request is outstanding; not enforced.
// Sequencing. Puts, newlines, cursor moves and no-ops leave the queue and
// pass through the FINISH state to the result register; cell reads pass
// through READ first. Clear and any move that scrolls sweep the cell RAM one
// cell per cycle through its single write port before FINISH.
// A two-entry queue lets the front end keep taking requests during a sweep.
// Reset. rst_n is synchronous and active low. After it the back end fills the
// cell RAM with blanks, holding in_stall high meanwhile.
// Stalls. While out_stall is high the result is held; the back end finishes
// its current request and then waits, and the queue fills before in_stall rises.
`default_nettype none
`include "text_console_writer_defines.svh"

module text_console_writer import tcw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CMD_W-1:0]      in_cmd,
  input  wire logic [CHAR_W-1:0]     in_ch,
  input  wire logic [COLOR_W-1:0]    in_fg,
  input  wire logic [COLOR_W-1:0]    in_bg,
  input  wire logic [COL_IN_W-1:0]   in_col,
  input  wire logic [ROW_IN_W-1:0]   in_row,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [POS_W-1:0]           out_cursor_pos,
  output logic [CELL_W-1:0]          out_read_entry,
  output logic                       out_scrolled,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS = COLS * ROWS;

  logic               text_mode_r, text_mode_nxt;
  logic [COLOR_W-1:0] default_fg_r, default_fg_nxt;
  logic [COLOR_W-1:0] default_bg_r, default_bg_nxt;

  logic   q_push, q_full, q_pop, q_valid, init_busy;
  entry_t push_entry, head_entry;

  // The register file takes a write every cycle.
  assign cfg_ready = 1'b1;

  always_comb begin
    text_mode_nxt  = text_mode_r;
    default_fg_nxt = default_fg_r;
    default_bg_nxt = default_bg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEXT_MODE:  text_mode_nxt  = cfg_data[0];
        CFG_DEFAULT_FG: default_fg_nxt = cfg_data;
        CFG_DEFAULT_BG: default_bg_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_mode_r  <= 1'b1;
      default_fg_r <= RESET_FG;
      default_bg_r <= RESET_BG;
    end else begin
      text_mode_r  <= text_mode_nxt;
      default_fg_r <= default_fg_nxt;
      default_bg_r <= default_bg_nxt;
    end
  end

  // Front end decodes the request against the current configuration.
  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_ch      (in_ch),
    .in_fg      (in_fg),
    .in_bg      (in_bg),
    .in_col     (in_col),
    .in_row     (in_row),
    .text_mode  (text_mode_r),
    .default_fg (default_fg_r),
    .default_bg (default_bg_r),
    .init_busy  (init_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (head_entry)
  );

  // Back end owns the cursor, the cell RAM and the result register.
  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (head_entry),
    .q_pop          (q_pop),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_pos (out_cursor_pos),
    .out_read_entry (out_read_entry),
    .out_scrolled   (out_scrolled)
  );

  `TCW_ASSERT_NEXT(a_reset_drops_result, clk, !rst_n, !out_valid, "result valid after reset")
  `TCW_ASSERT(a_scroll_not_read, clk, rst_n, out_valid && out_scrolled, out_read_entry == 16'h0000, "scroll reported with read data")
  `TCW_ASSERT(a_pos_on_screen, clk, rst_n, out_valid, (CELLS > 2048) || (out_cursor_pos < CELLS), "cursor position off screen")
  `TCW_ASSERT(a_scroll_last_row, clk, rst_n, out_valid && out_scrolled, (CELLS > 2048) || (out_cursor_pos >= (ROWS - 1) * COLS), "scroll left cursor above last row")

endmodule

`default_nettype wire

/* rtl/core/tcw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/tcw_front.sv */
// Front end: takes requests and turns each into a decoded queue entry.
// Depends on tcw_pkg.
`default_nettype none

module tcw_front import tcw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [CHAR_W-1:0]   in_ch,
  input  wire logic [COLOR_W-1:0]  in_fg,
  input  wire logic [COLOR_W-1:0]  in_bg,
  input  wire logic [COL_IN_W-1:0] in_col,
  input  wire logic [ROW_IN_W-1:0] in_row,
  input  wire logic                text_mode,
  input  wire logic [COLOR_W-1:0]  default_fg,
  input  wire logic [COLOR_W-1:0]  default_bg,
  input  wire logic                init_busy,
  input  wire logic                q_full,
  output logic                     q_push,
  output entry_t                   q_entry
);

  logic read_ok;

  // Reads outside the screen become no-ops, so they simply return zero.
  assign read_ok  = (32'(in_col) < COLS) && (32'(in_row) < ROWS);
  assign in_stall = q_full | init_busy;
  assign q_push   = in_valid & ~in_stall;

  always_comb begin
    q_entry.op        = OP_NOP;
    q_entry.cell_word = {default_bg, default_fg, BLANK_CHAR};
    q_entry.col       = in_col;
    q_entry.row       = in_row;
    if (text_mode) begin
      unique case (in_cmd) inside
        CMD_PUT_DEFAULT, CMD_PUT_COLOR: begin
          if (in_ch == NEWLINE_CHAR) begin
            q_entry.op = OP_NEWLINE;
          end else begin
            q_entry.op = OP_PUT;
            if (in_cmd == CMD_PUT_COLOR) begin
              q_entry.cell_word = {in_bg, in_fg, in_ch};
            end else begin
              q_entry.cell_word = {default_bg, default_fg, in_ch};
            end
          end
        end
        CMD_SET_CURSOR: q_entry.op = OP_SETCUR;
        CMD_CLEAR:      q_entry.op = OP_CLEAR;
        CMD_READ:       q_entry.op = read_ok ? OP_READ : OP_NOP;
        default:        q_entry.op = OP_NOP;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tcw_queue.sv */
// Two-entry queue of decoded requests between the front and back ends.
// Depends on tcw_pkg.
`default_nettype none

module tcw_queue import tcw_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        valid,
  output entry_t      head
);

  entry_t     slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tcw_back.sv */
// Back end: owns the cursor and the cell RAM, executes queued operations
// and holds the result register. Depends on tcw_pkg and tcw_ram.
`default_nettype none

module tcw_back import tcw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire entry_t            q_entry,
  output logic                   q_pop,
  output logic                   init_busy,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [POS_W-1:0]       out_cursor_pos,
  output logic [CELL_W-1:0]      out_read_entry,
  output logic                   out_scrolled
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int AW1   = AW + 1;
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int IW    = (AW > POS_W) ? AW : POS_W;

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_CLEAR  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cur_col_r, cur_col_nxt;
  logic [RW-1:0]       cur_row_r, cur_row_nxt;
  logic [AW-1:0]       sweep_r, sweep_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic                pend_zero_r, pend_zero_nxt;
  logic [CELL_W-1:0]   fill_r, fill_nxt;
  logic [CELL_W-1:0]   res_rd_r, res_rd_nxt;
  logic                res_scr_r, res_scr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [CELL_W-1:0]   out_rd_r, out_rd_nxt;
  logic                out_scr_r, out_scr_nxt;

  logic [X_W-1:0]      x_t, x_w;
  logic [Y_W-1:0]      y_t, y_w, y_f;
  logic                wrap, do_scroll;
  logic [IW-1:0]       cur_lin, rd_lin;
  logic [AW1-1:0]      scr_src;
  logic                scr_src_ok;
  logic                sweep_last;
  logic                slot_free;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_lin    = IW'(cur_row_r) * IW'(COLS) + IW'(cur_col_r);
  assign rd_lin     = IW'(q_entry.row) * IW'(COLS) + IW'(q_entry.col);
  assign scr_src    = {1'b0, sweep_r} + AW1'(COLS);
  assign scr_src_ok = scr_src < AW1'(CELLS);
  assign sweep_last = (sweep_r == AW'(CELLS - 1));
  assign slot_free  = ~out_valid_r | ~out_stall;

  assign init_busy      = (state_r == ST_INIT);
  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_read_entry = out_rd_r;
  assign out_scrolled   = out_scr_r;

  // Target of a cursor move, then wrap and a single scroll.
  always_comb begin
    case (q_entry.op)
      OP_PUT: begin
        x_t = X_W'(cur_col_r) + X_W'(1);
        y_t = Y_W'(cur_row_r);
      end
      OP_NEWLINE: begin
        x_t = '0;
        y_t = Y_W'(cur_row_r) + Y_W'(1);
      end
      default: begin
        x_t = X_W'(q_entry.col);
        y_t = Y_W'(q_entry.row);
      end
    endcase
    wrap      = x_t >= X_W'(COLS);
    x_w       = wrap ? '0 : x_t;
    y_w       = wrap ? y_t + Y_W'(1) : y_t;
    do_scroll = y_w >= Y_W'(ROWS);
    y_f       = do_scroll ? Y_W'(ROWS - 1) : y_w;
  end

  // RAM port selection. A pending scroll copy owns the write port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_r;
    ram_wdata = RESET_CELL;
    ram_raddr = rd_lin[AW-1:0];
    if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_zero_r ? '0 : ram_rdata;
    end else if (state_r == ST_INIT) begin
      ram_we    = 1'b1;
    end else if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_wdata = fill_r;
    end else if (state_r == ST_IDLE && q_valid && q_entry.op == OP_PUT) begin
      ram_we    = 1'b1;
      ram_waddr = cur_lin[AW-1:0];
      ram_wdata = q_entry.cell_word;
    end
    if (state_r == ST_SCROLL) begin
      ram_raddr = scr_src_ok ? scr_src[AW-1:0] : '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    sweep_nxt     = sweep_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_zero_nxt = pend_zero_r;
    fill_nxt      = fill_r;
    res_rd_nxt    = res_rd_r;
    res_scr_nxt   = res_scr_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_pos_nxt   = out_pos_r;
    out_rd_nxt    = out_rd_r;
    out_scr_nxt   = out_scr_r;
    q_pop         = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_last) begin
          sweep_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          res_rd_nxt  = '0;
          res_scr_nxt = 1'b0;
          sweep_nxt   = '0;
          unique case (q_entry.op) inside
            OP_PUT, OP_NEWLINE, OP_SETCUR: begin
              cur_col_nxt = CW'(x_w);
              cur_row_nxt = RW'(y_f);
              res_scr_nxt = do_scroll;
              state_nxt   = do_scroll ? ST_SCROLL : ST_FINISH;
            end
            OP_CLEAR: begin
              fill_nxt  = q_entry.cell_word;
              state_nxt = ST_CLEAR;
            end
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_READ: begin
        res_rd_nxt = ram_rdata;
        state_nxt  = ST_FINISH;
      end
      ST_SCROLL: begin
        // Read the cell one row down now, write it one row up next cycle.
        pend_nxt      = 1'b1;
        pend_addr_nxt = sweep_r;
        pend_zero_nxt = ~scr_src_ok;
        sweep_nxt     = sweep_r + AW'(1);
        if (sweep_last) begin
          sweep_nxt = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_CLEAR: begin
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_last) begin
          sweep_nxt = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = cur_lin[POS_W-1:0];
          out_rd_nxt    = res_rd_r;
          out_scr_nxt   = res_scr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      sweep_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      sweep_r     <= sweep_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_zero_r <= pend_zero_nxt;
    fill_r      <= fill_nxt;
    res_rd_r    <= res_rd_nxt;
    res_scr_r   <= res_scr_nxt;
    out_pos_r   <= out_pos_nxt;
    out_rd_r    <= out_rd_nxt;
    out_scr_r   <= out_scr_nxt;
  end

endmodule

`default_nettype wire
